### rtl/usan_pkg.sv
// Shared types, command codes and byte-judging functions for the UTF-8 sanitiser.
package usan_pkg;

  // Substitute byte after reset ('?')
  localparam logic [7:0] SUBST_RESET = 8'h3f;

  // Summary widths and saturation limit of the error count
  localparam int COUNT_W = 17;
  localparam int INDEX_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Datapath commands issued by the controller
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;  // nothing this cycle
  localparam op_t OP_LOAD  = 3'd1;  // append the accepted byte to the window
  localparam op_t OP_HOLD  = 3'd2;  // keep the judged byte as part of a sequence
  localparam op_t OP_PASS  = 3'd3;  // emit the front byte unchanged, shift
  localparam op_t OP_FAIL  = 3'd4;  // emit the substitute for the front byte, rescan
  localparam op_t OP_CLOSE = 3'd5;  // release the pending word, end of run

  // Verdict on the byte under the judge pointer
  typedef logic [1:0] verdict_t;
  localparam verdict_t V_BAD      = 2'd0;  // front byte must be substituted
  localparam verdict_t V_SINGLE   = 2'd1;  // plain ASCII byte
  localparam verdict_t V_HOLD     = 2'd2;  // sequence still open
  localparam verdict_t V_COMPLETE = 2'd3;  // sequence closes with this byte

  typedef struct packed {
    op_t  op;
    logic last;   // the word being worked on ends the stream
  } cmd_t;

  typedef struct packed {
    verdict_t verdict;
    logic     have_byte;   // an unjudged byte sits in the window
    logic     held_none;   // no bytes held
    logic     held_one;    // exactly one byte held
    logic     pend_valid;  // a result waits in the pending stage
    logic     out_free;    // output register can take a result this cycle
  } stat_t;

  // Sequence length from a lead byte: 0 invalid lead, 1 single byte, 2..6 sequence
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b == 8'h00) begin
      len = 3'd0;
    end else if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b < 8'hc0 || b >= 8'hfe) begin
      len = 3'd0;
    end else if ((b & 8'he0) == 8'hc0) begin
      len = 3'd2;
    end else if ((b & 8'hf0) == 8'he0) begin
      len = 3'd3;
    end else if ((b & 8'hf8) == 8'hf0) begin
      len = 3'd4;
    end else if ((b & 8'hfc) == 8'hf8) begin
      len = 3'd5;
    end else begin
      len = 3'd6;
    end
    return len;
  endfunction

  // Judge trailing byte b at offset k, lead c, second byte s
  function automatic logic cont_bad(input logic [2:0] k, input logic [7:0] b,
                                    input logic [7:0] c, input logic [7:0] s,
                                    input logic [2:0] seq_len);
    logic bad;
    bad = 1'b0;
    if (b[7:6] != 2'b10) begin
      bad = 1'b1;
    end else if (k == 3'd1) begin
      // overlong forms
      unique case (seq_len)
        3'd2:    bad = (c & 8'h3e) == 8'h00;
        3'd3:    bad = c == 8'he0 && (b & 8'h20) == 8'h00;
        3'd4:    bad = c == 8'hf0 && (b & 8'h30) == 8'h00;
        3'd5:    bad = c == 8'hf8 && (b & 8'h38) == 8'h00;
        3'd6:    bad = c == 8'hfc && (b & 8'h3c) == 8'h00;
        default: bad = 1'b0;
      endcase
    end else if (k == 3'd2 && seq_len == 3'd3) begin
      // listed surrogate code points and the two non-characters
      if (c == 8'hed && b == 8'h80 &&
          (s == 8'ha0 || s == 8'hae || s == 8'hb0 || s == 8'hbe)) begin
        bad = 1'b1;
      end
      if (c == 8'hed && b == 8'hbf && (s == 8'had || s == 8'haf || s == 8'hbf)) begin
        bad = 1'b1;
      end
      if (c == 8'hef && s == 8'hbf && (b == 8'hbe || b == 8'hbf)) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

endpackage

### rtl/usan_if.sv
// Valid/ready channel interfaces for the sanitiser's byte input and result output.
interface usan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface usan_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        replaced;
  logic        run_end;
  logic        stream_end;
  logic        error_found;
  logic [15:0] first_error_index;
  logic [16:0] error_count;

  modport source (output valid, output out_byte, output replaced, output run_end,
                  output stream_end, output error_found, output first_error_index,
                  output error_count, input ready);
  modport sink   (input valid, input out_byte, input replaced, input run_end,
                  input stream_end, input error_found, input first_error_index,
                  input error_count, output ready);
endinterface

### rtl/usan_datapath.sv
// Byte window, judge logic, statistics and output stages of the sanitiser.
module usan_datapath #(
  parameter int              MAX_SEQ    = 6,
  parameter longint unsigned MAX_STREAM = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  usan_pkg::cmd_t               cmd,
  output usan_pkg::stat_t              stat,
  input  logic [7:0]                   in_byte,
  input  logic                         cfg_we,
  input  logic [7:0]                   cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_rep,
  output logic                         out_run_end,
  output logic                         out_stream_end,
  output logic                         out_err,
  output logic [usan_pkg::INDEX_W-1:0] out_first,
  output logic [usan_pkg::COUNT_W-1:0] out_count
);

  localparam int IdxW = $clog2(MAX_SEQ);
  localparam int CntW = $clog2(MAX_SEQ + 1);
  localparam int PosW = $clog2(MAX_STREAM);
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_STREAM - 1);

  // window: front entries are held, the rest wait to be judged
  logic [7:0]                   held [MAX_SEQ];
  logic [CntW-1:0]              fill;
  logic [CntW-1:0]              judged;
  logic [2:0]                   seq_len;
  logic [PosW-1:0]              head_pos;
  logic [7:0]                   subst;
  logic                         bad_seen;
  logic [usan_pkg::INDEX_W-1:0] first_bad;
  logic [usan_pkg::COUNT_W-1:0] bad_total;
  logic                         pend_valid;
  logic [7:0]                   pend_byte;
  logic                         pend_rep;

  logic [7:0]          cur;
  logic [2:0]          raw_len;
  logic                len_ok;
  logic [CntW-1:0]     judged_inc;
  logic                emit;
  logic                out_load;
  logic                stream_done;
  logic [PosW-1:0]     head_pos_inc;
  usan_pkg::verdict_t  verdict;

  // judge the byte under the pointer
  always_comb begin
    cur        = held[judged[IdxW-1:0]];
    raw_len    = usan_pkg::lead_len(cur);
    len_ok     = raw_len != 3'd0 && raw_len <= 3'(MAX_SEQ);
    judged_inc = judged + CntW'(1);
    if (judged == '0) begin
      if (!len_ok) begin
        verdict = usan_pkg::V_BAD;
      end else if (raw_len == 3'd1) begin
        verdict = usan_pkg::V_SINGLE;
      end else begin
        verdict = usan_pkg::V_HOLD;
      end
    end else if (usan_pkg::cont_bad(3'(judged), cur, held[0], held[1], seq_len)) begin
      verdict = usan_pkg::V_BAD;
    end else if (3'(judged_inc) >= seq_len) begin
      verdict = usan_pkg::V_COMPLETE;
    end else begin
      verdict = usan_pkg::V_HOLD;
    end
  end

  // stage moves
  assign emit         = cmd.op == usan_pkg::OP_PASS || cmd.op == usan_pkg::OP_FAIL;
  assign out_load     = pend_valid && (emit || cmd.op == usan_pkg::OP_CLOSE);
  assign stream_done  = cmd.op == usan_pkg::OP_CLOSE && cmd.last;
  assign head_pos_inc = (head_pos == PosLast) ? '0 : head_pos + PosW'(1);

  // status to the controller
  always_comb begin
    stat.verdict    = verdict;
    stat.have_byte  = judged < fill;
    stat.held_none  = judged == '0;
    stat.held_one   = judged == CntW'(1);
    stat.pend_valid = pend_valid;
    stat.out_free   = !out_valid || out_ready;
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      judged     <= '0;
      seq_len    <= '0;
      head_pos   <= '0;
      subst      <= usan_pkg::SUBST_RESET;
      bad_seen   <= 1'b0;
      first_bad  <= '0;
      bad_total  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        subst <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid <= 1'b1;
      end
      unique case (cmd.op)
        usan_pkg::OP_NONE: begin
        end
        usan_pkg::OP_LOAD: begin
          fill <= fill + CntW'(1);
        end
        usan_pkg::OP_HOLD: begin
          if (judged == '0) begin
            seq_len <= raw_len;
          end
          judged <= judged_inc;
        end
        usan_pkg::OP_PASS: begin
          fill     <= fill - CntW'(1);
          head_pos <= head_pos_inc;
          if (judged != '0) begin
            judged <= judged - CntW'(1);
          end
        end
        usan_pkg::OP_FAIL: begin
          fill     <= fill - CntW'(1);
          head_pos <= head_pos_inc;
          judged   <= '0;
          bad_seen <= 1'b1;
          if (!bad_seen) begin
            first_bad <= usan_pkg::INDEX_W'(head_pos);
          end
          if (bad_total != usan_pkg::COUNT_MAX) begin
            bad_total <= bad_total + usan_pkg::COUNT_W'(1);
          end
        end
        usan_pkg::OP_CLOSE: begin
          pend_valid <= 1'b0;
          if (cmd.last) begin
            fill      <= '0;
            judged    <= '0;
            seq_len   <= '0;
            head_pos  <= '0;
            bad_seen  <= 1'b0;
            first_bad <= '0;
            bad_total <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // window contents, pending word and output word
  always_ff @(posedge clk) begin
    if (cmd.op == usan_pkg::OP_LOAD) begin
      held[fill[IdxW-1:0]] <= in_byte;
    end
    if (emit) begin
      for (int i = 0; i < MAX_SEQ - 1; i++) begin
        held[i] <= held[i+1];
      end
      pend_byte <= (cmd.op == usan_pkg::OP_FAIL) ? subst : held[0];
      pend_rep  <= cmd.op == usan_pkg::OP_FAIL;
    end
    if (out_load) begin
      out_byte       <= pend_byte;
      out_rep        <= pend_rep;
      out_run_end    <= cmd.op == usan_pkg::OP_CLOSE;
      out_stream_end <= stream_done;
      out_err        <= stream_done && bad_seen;
      out_first      <= stream_done ? first_bad : '0;
      out_count      <= stream_done ? bad_total : '0;
    end
  end

endmodule

### rtl/usan_ctrl.sv
// Sequencer that walks each input word through judge, emit and close steps.
module usan_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_is_last,
  output logic            in_ready,
  input  usan_pkg::stat_t stat,
  output usan_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_CLOSE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       last_flag;
  logic       can_emit;

  // a new result fits when the pending stage is empty or can move on
  assign can_emit = !stat.pend_valid || stat.out_free;
  assign in_ready = state == ST_IDLE;

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op     = usan_pkg::OP_NONE;
    cmd.last   = last_flag;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = usan_pkg::OP_LOAD;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.have_byte) begin
          unique case (stat.verdict)
            usan_pkg::V_BAD: begin
              if (can_emit) begin
                cmd.op = usan_pkg::OP_FAIL;
              end
            end
            usan_pkg::V_SINGLE: begin
              if (can_emit) begin
                cmd.op = usan_pkg::OP_PASS;
              end
            end
            usan_pkg::V_HOLD: begin
              cmd.op = usan_pkg::OP_HOLD;
            end
            usan_pkg::V_COMPLETE: begin
              cmd.op     = usan_pkg::OP_HOLD;
              state_next = ST_DRAIN;
            end
            default: begin
            end
          endcase
        end else if (last_flag && !stat.held_none) begin
          // sequence cut short by the end of the stream
          if (can_emit) begin
            cmd.op = usan_pkg::OP_FAIL;
          end
        end else begin
          state_next = ST_CLOSE;
        end
      end
      ST_DRAIN: begin
        if (can_emit) begin
          cmd.op = usan_pkg::OP_PASS;
          if (stat.held_one) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          cmd.op     = usan_pkg::OP_CLOSE;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        last_flag <= in_is_last;
      end
    end
  end

endmodule

### rtl/utf8_stream_sanitizer_core.sv
// Top level of the streaming UTF-8 sanitiser with lead-byte substitution.
//
//   channel  dir  payload                                    word
//   rx       in   in_byte, is_last                           one stream byte
//   tx       out  out_byte, replaced, run_end, stream_end,   one output byte
//                 error_found, first_error_index, error_count
//   cfg      in   cfg_wdata on cfg_we                        substitute byte
//
// One input word at a time: an accepted word is worked through in k steps, k being the
// number of one-byte judge and emit steps it sets off in the sequencer (1 for
// plain ASCII, at most MAX_SEQUENCE_BYTES + 1 when a longest sequence completes,
// or fails and is rescanned). rx is ready only while the sequencer is idle; an
// output register and a pending stage let the next word in while a result
// still waits on tx. A tx stall holds the sequencer at an emit or close step
// once the pending stage is full. rst is synchronous.
module utf8_stream_sanitizer_core #(
  parameter int              MAX_SEQUENCE_BYTES = 6,
  parameter longint unsigned MAX_STREAM_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst,
  usan_in_if.sink     rx,
  usan_out_if.source  tx,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  usan_pkg::cmd_t  cmd;
  usan_pkg::stat_t stat;

  // sequencer
  usan_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_is_last (rx.is_last),
    .in_ready   (rx.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // byte window, judge and output stages
  usan_datapath #(
    .MAX_SEQ    (MAX_SEQUENCE_BYTES),
    .MAX_STREAM (MAX_STREAM_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_byte        (rx.in_byte),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (tx.valid),
    .out_ready      (tx.ready),
    .out_byte       (tx.out_byte),
    .out_rep        (tx.replaced),
    .out_run_end    (tx.run_end),
    .out_stream_end (tx.stream_end),
    .out_err        (tx.error_found),
    .out_first      (tx.first_error_index),
    .out_count      (tx.error_count)
  );

endmodule

### rtl/usan_checker.sv
// Port-level checks on the sanitiser top level, bound to it.
module usan_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic        tx_valid,
  input logic        tx_ready,
  input logic [7:0]  tx_out_byte,
  input logic        tx_run_end,
  input logic        tx_stream_end,
  input logic        tx_error_found,
  input logic [15:0] tx_first_error_index,
  input logic [16:0] tx_error_count
);

  // one input word in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready |=> !rx_ready)
    else $error("input taken while a word is still in work");

  // the end of a stream also closes the run
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_stream_end |-> tx_run_end)
    else $error("stream end without run end");

  // summary fields stay zero away from the end of a stream
  a_summary_quiet: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_stream_end |->
      !tx_error_found && tx_first_error_index == 16'd0 && tx_error_count == 17'd0)
    else $error("summary fields set before stream end");

  // error flag and count agree
  a_flag_count: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_stream_end |-> tx_error_found == (tx_error_count != 17'd0))
    else $error("error flag disagrees with error count");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_byte) && $stable(tx_run_end))
    else $error("output word changed under stall");

endmodule

bind utf8_stream_sanitizer_core usan_checker u_usan_checker (
  .clk                  (clk),
  .rst                  (rst),
  .rx_valid             (rx.valid),
  .rx_ready             (rx.ready),
  .tx_valid             (tx.valid),
  .tx_ready             (tx.ready),
  .tx_out_byte          (tx.out_byte),
  .tx_run_end           (tx.run_end),
  .tx_stream_end        (tx.stream_end),
  .tx_error_found       (tx.error_found),
  .tx_first_error_index (tx.first_error_index),
  .tx_error_count       (tx.error_count)
);
